### rtl/sva_pkg.sv
// Shared constants, codes and types of the synth voice allocator.
package sva_pkg;

  // Voice pool geometry.
  localparam int VOICE_COUNT = 16;
  localparam int VC_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W = $clog2(VOICE_COUNT + 1);

  // Field widths fixed by the interface.
  localparam int AGE_W = 32;
  localparam int LVL_W = 16;
  localparam int POLY_W = 5;
  localparam logic [POLY_W-1:0] POLY_MIN = 5'd1;
  localparam logic [POLY_W-1:0] POLY_MAX = 5'd16;

  // Request codes.
  localparam logic [2:0] REQ_NOTE_ON = 3'd0;
  localparam logic [2:0] REQ_NOTE_OFF = 3'd1;
  localparam logic [2:0] REQ_PEDAL = 3'd2;
  localparam logic [2:0] REQ_ALL_NOTES_OFF = 3'd3;
  localparam logic [2:0] REQ_ALL_SOUND_OFF = 3'd4;
  localparam logic [2:0] REQ_VOICE_FINISHED = 3'd5;
  localparam logic [2:0] REQ_LEVEL_REPORT = 3'd6;

  // Command codes.
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_CUT = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_FADE = 3'd4;
  localparam logic [2:0] CMD_SILENCE = 3'd5;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SCAN    = 7'b0000010,
    ST_STEAL   = 7'b0000100,
    ST_START   = 7'b0001000,
    ST_CUTSCAN = 7'b0010000,
    ST_CUT     = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  // One voice command.
  typedef struct packed {
    logic [2:0] command;
    logic [3:0] voice;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       retrigger;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    state_t          state;
    logic [VC_W-1:0] idx;
    logic            load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stall;
    logic note_on;
    logic held_found;
    logic free_found;
  } dp_stat_t;

endpackage

### rtl/sva_ctrl.sv
// Sequencer of the voice allocator: steps through the scan phases of an event.
module sva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sva_pkg::dp_stat_t stat,
  output sva_pkg::ctl_cmd_t cmd
);
  import sva_pkg::*;

  state_t          state_r, state_nxt;
  logic [VC_W-1:0] idx_r, idx_nxt;
  logic            idx_last;

  assign idx_last = (idx_r == VC_W'(VOICE_COUNT - 1));
  assign in_stall = (state_r != ST_IDLE);

  assign cmd.state = state_r;
  assign cmd.idx = idx_r;
  assign cmd.load = in_valid && (state_r == ST_IDLE);

  // Next state and scan index.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stat.stall) begin
          if (idx_last) begin
            idx_nxt = '0;
            state_nxt = stat.note_on ? ST_STEAL : ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_STEAL: begin
        if (!stat.stall) state_nxt = stat.held_found ? ST_DONE : ST_START;
      end
      ST_START: begin
        idx_nxt = '0;
        if (!stat.stall) state_nxt = stat.free_found ? ST_DONE : ST_CUTSCAN;
      end
      ST_CUTSCAN: begin
        if (idx_last) begin
          idx_nxt = '0;
          state_nxt = ST_CUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CUT: begin
        if (!stat.stall) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/sva_datapath.sv
// Voice table, scan accumulators and command output stage of the allocator.
module sva_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sva_pkg::ctl_cmd_t             cmd,
  output sva_pkg::dp_stat_t             stat,
  input  logic [2:0]                    in_req_type,
  input  logic [3:0]                    in_channel,
  input  logic [6:0]                    in_note,
  input  logic [6:0]                    in_velocity,
  input  logic                          in_pedal_down,
  input  logic [3:0]                    in_voice_slot,
  input  logic [15:0]                   in_level,
  input  logic [sva_pkg::POLY_W-1:0]    polyphony,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sva_pkg::res_t                 out_res,
  output logic                          out_last
);
  import sva_pkg::*;

  // Latched event.
  logic [2:0] ev_type_r;
  logic [3:0] ev_ch_r;
  logic [6:0] ev_note_r;
  logic [6:0] ev_vel_r;
  logic       ev_down_r;

  // Voice table.
  logic [VOICE_COUNT-1:0] act_r, act_nxt;
  logic [VOICE_COUNT-1:0] rel_r, rel_nxt;
  logic [VOICE_COUNT-1:0] held_r, held_nxt;
  logic [3:0]             ch_mem [VOICE_COUNT];
  logic [6:0]             note_mem [VOICE_COUNT];
  logic [AGE_W-1:0]       age_mem [VOICE_COUNT];
  logic [LVL_W-1:0]       lvl_r [VOICE_COUNT];
  logic                   pedal_r;
  logic [AGE_W-1:0]       age_ctr_r;

  // Scan accumulators.
  logic [CNT_W-1:0] cnt_r;
  logic             old_found_r, held_found_r, free_found_r, tgt_found_r;
  logic [VC_W-1:0]  old_idx_r, held_idx_r, free_idx_r, tgt_idx_r;
  logic [AGE_W-1:0] old_age_r;
  logic             tgt_rel_r;
  logic [LVL_W-1:0] tgt_lvl_r;

  // Result staging: one command waits in hold until the next shows whether it was last.
  logic hold_v_r;
  res_t hold_r;
  logic out_v_r;
  res_t out_r;
  logic out_last_r;

  logic [VC_W-1:0] i;
  logic            cur_act, cur_rel, cur_snd, cur_match;
  logic            in_scan, go, can_push, emit_now, push_hold, steal_cond;
  logic            slot_ok, start_we;
  logic [VC_W-1:0] slot_idx, start_idx;
  res_t            em;

  assign i = cmd.idx;
  assign cur_act = act_r[i];
  assign cur_rel = rel_r[i];
  assign cur_snd = cur_act && !cur_rel;
  assign cur_match = cur_act && (ch_mem[i] == ev_ch_r) && (note_mem[i] == ev_note_r);
  assign in_scan = (cmd.state == ST_SCAN);
  assign slot_ok = (32'(in_voice_slot) < VOICE_COUNT);
  assign slot_idx = in_voice_slot[VC_W-1:0];
  assign steal_cond = old_found_r && (32'(cnt_r) >= 32'(polyphony));

  // Command produced by the current step, if any.
  always_comb begin
    emit_now = 1'b0;
    em = '0;
    em.voice = 4'(i);
    case (cmd.state)
      ST_SCAN: begin
        case (ev_type_r)
          REQ_NOTE_ON: begin
            emit_now = cur_match && cur_rel;
            em.command = CMD_FADE;
          end
          REQ_NOTE_OFF: begin
            emit_now = cur_snd && cur_match && !pedal_r;
            em.command = CMD_RELEASE;
            em.velocity = ev_vel_r;
          end
          REQ_PEDAL: begin
            emit_now = !ev_down_r && held_r[i] && cur_snd;
            em.command = CMD_RELEASE;
          end
          REQ_ALL_NOTES_OFF: begin
            emit_now = cur_snd;
            em.command = CMD_RELEASE;
          end
          REQ_ALL_SOUND_OFF: begin
            emit_now = cur_act;
            em.command = CMD_SILENCE;
          end
          default: emit_now = 1'b0;
        endcase
      end
      ST_STEAL: begin
        if (held_found_r) begin
          emit_now = 1'b1;
          em.command = CMD_START;
          em.voice = 4'(held_idx_r);
          em.channel = ev_ch_r;
          em.note = ev_note_r;
          em.velocity = ev_vel_r;
          em.retrigger = 1'b1;
        end else begin
          emit_now = steal_cond;
          em.command = CMD_FADE;
          em.voice = 4'(old_idx_r);
        end
      end
      ST_START, ST_CUT: begin
        emit_now = (cmd.state == ST_CUT) || free_found_r;
        em.command = (cmd.state == ST_CUT) ? CMD_CUT : CMD_START;
        em.voice = 4'(start_idx);
        em.channel = ev_ch_r;
        em.note = ev_note_r;
        em.velocity = ev_vel_r;
      end
      default: emit_now = 1'b0;
    endcase
  end

  // A step waits while its command would displace a held one the output cannot take.
  assign can_push = !out_v_r || !out_stall;
  assign stat.stall = (emit_now || (cmd.state == ST_DONE)) && hold_v_r && !can_push;
  assign go = !stat.stall;
  assign push_hold = go && hold_v_r && (emit_now || (cmd.state == ST_DONE));
  assign stat.note_on = (ev_type_r == REQ_NOTE_ON);
  assign stat.held_found = held_found_r;
  assign stat.free_found = free_found_r;

  // A fresh start goes to the first free voice or to the cut target.
  assign start_idx = (cmd.state == ST_CUT) ? tgt_idx_r : free_idx_r;
  assign start_we = go && (((cmd.state == ST_START) && free_found_r) || (cmd.state == ST_CUT));

  // Flag vectors.
  always_comb begin
    act_nxt = act_r;
    rel_nxt = rel_r;
    held_nxt = held_r;
    if (cmd.load && (in_req_type == REQ_VOICE_FINISHED) && slot_ok) begin
      act_nxt[slot_idx] = 1'b0;
      rel_nxt[slot_idx] = 1'b0;
      held_nxt[slot_idx] = 1'b0;
    end
    if (go && in_scan) begin
      case (ev_type_r)
        REQ_NOTE_OFF: begin
          if (cur_snd && cur_match) begin
            if (pedal_r) held_nxt[i] = 1'b1;
            else rel_nxt[i] = 1'b1;
          end
        end
        REQ_PEDAL: begin
          if (!ev_down_r && held_r[i]) begin
            if (cur_snd) rel_nxt[i] = 1'b1;
            held_nxt[i] = 1'b0;
          end
        end
        REQ_ALL_NOTES_OFF: begin
          if (cur_snd) rel_nxt[i] = 1'b1;
          held_nxt[i] = 1'b0;
        end
        REQ_ALL_SOUND_OFF: begin
          act_nxt[i] = 1'b0;
          rel_nxt[i] = 1'b0;
          held_nxt[i] = 1'b0;
        end
        default: held_nxt = held_r;
      endcase
    end
    if (go && (cmd.state == ST_STEAL)) begin
      if (held_found_r) held_nxt[held_idx_r] = 1'b0;
      else if (steal_cond) rel_nxt[old_idx_r] = 1'b1;
    end
    if (start_we) begin
      act_nxt[start_idx] = 1'b1;
      rel_nxt[start_idx] = 1'b0;
      held_nxt[start_idx] = 1'b0;
    end
  end

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      rel_r <= '0;
      held_r <= '0;
      pedal_r <= 1'b0;
      age_ctr_r <= '0;
    end else begin
      act_r <= act_nxt;
      rel_r <= rel_nxt;
      held_r <= held_nxt;
      if (cmd.load) begin
        if (in_req_type == REQ_PEDAL) pedal_r <= in_pedal_down;
        else if ((in_req_type == REQ_ALL_NOTES_OFF) || (in_req_type == REQ_ALL_SOUND_OFF))
          pedal_r <= 1'b0;
      end
      if (start_we || (go && (cmd.state == ST_STEAL) && held_found_r))
        age_ctr_r <= age_ctr_r + 1'b1;
    end
  end

  // Per-voice key and age: both written on a start, the age alone on a retrigger.
  always_ff @(posedge clk) begin
    for (int k = 0; k < VOICE_COUNT; k++) begin
      if (start_we && (start_idx == VC_W'(k))) begin
        ch_mem[k] <= ev_ch_r;
        note_mem[k] <= ev_note_r;
        age_mem[k] <= age_ctr_r + 1'b1;
      end else if (go && (cmd.state == ST_STEAL) && held_found_r &&
                   (held_idx_r == VC_W'(k))) begin
        age_mem[k] <= age_ctr_r + 1'b1;
      end
    end
  end

  // Voice levels.
  always_ff @(posedge clk) begin
    for (int k = 0; k < VOICE_COUNT; k++) begin
      if (!rst_n) begin
        lvl_r[k] <= '0;
      end else if (cmd.load && slot_ok && (slot_idx == VC_W'(k)) &&
                   (in_req_type == REQ_LEVEL_REPORT)) begin
        lvl_r[k] <= in_level;
      end else if ((cmd.load && slot_ok && (slot_idx == VC_W'(k)) &&
                    (in_req_type == REQ_VOICE_FINISHED)) ||
                   (go && in_scan && (ev_type_r == REQ_ALL_SOUND_OFF) &&
                    (i == VC_W'(k))) ||
                   (start_we && (start_idx == VC_W'(k)))) begin
        lvl_r[k] <= '0;
      end
    end
  end

  // Event latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_type_r <= in_req_type;
      ev_ch_r <= in_channel;
      ev_note_r <= in_note;
      ev_vel_r <= in_velocity;
      ev_down_r <= in_pedal_down;
    end
  end

  // Scan accumulators: held key, sounding count, oldest, first free, cut target.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      cnt_r <= '0;
      old_found_r <= 1'b0;
      held_found_r <= 1'b0;
      free_found_r <= 1'b0;
      tgt_found_r <= 1'b0;
    end else if (go && in_scan && (ev_type_r == REQ_NOTE_ON)) begin
      if (cur_match && !cur_rel) begin
        held_found_r <= 1'b1;
        held_idx_r <= i;
      end
      if (cur_snd) begin
        cnt_r <= cnt_r + 1'b1;
        if (!old_found_r || (age_mem[i] < old_age_r)) begin
          old_found_r <= 1'b1;
          old_idx_r <= i;
          old_age_r <= age_mem[i];
        end
      end
      if (!cur_act && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r <= i;
      end
    end else if (cmd.state == ST_CUTSCAN) begin
      if (!tgt_found_r || (cur_rel && !tgt_rel_r) ||
          ((cur_rel == tgt_rel_r) && (lvl_r[i] < tgt_lvl_r))) begin
        tgt_found_r <= 1'b1;
        tgt_idx_r <= i;
        tgt_rel_r <= cur_rel;
        tgt_lvl_r <= lvl_r[i];
      end
    end
  end

  // Hold and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (go && emit_now) hold_v_r <= 1'b1;
      else if (go && (cmd.state == ST_DONE)) hold_v_r <= 1'b0;
      if (push_hold) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
    if (go && emit_now) hold_r <= em;
    if (push_hold) begin
      out_r <= hold_r;
      out_last_r <= (cmd.state == ST_DONE);
    end
  end

  assign out_valid = out_v_r;
  assign out_res = out_r;
  assign out_last = out_last_r;

endmodule

### rtl/synth_voice_allocator.sv
// Top level of the synth voice allocator: ports, polyphony register, sequencer and datapath.
//
// The allocator takes one event at a time and walks the sixteen voice entries one per
// cycle while the result side does not stall. Level reports, voice-finished and other events
// without commands make one pass over the table. Note off, pedal and all-off events make the
// same pass and can also stall on the result side. A note on makes that pass and a steal step;
// a retrigger ends there, else a start step follows, and when the pool is full a second scan
// finds the quietest voice to cut. Every note on can also stall on the result side. Results
// leave through an output register, and each command is held one step so that the final one
// of an event can carry last.
module synth_voice_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_channel,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_velocity,
  input  logic        in_pedal_down,
  input  logic [3:0]  in_voice_slot,
  input  logic [15:0] in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_command,
  output logic [3:0]  out_target_voice,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic        out_retrigger,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sva_pkg::*;

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  res_t              res;
  logic [POLY_W-1:0] poly_r;
  logic [POLY_W-1:0] poly_wr;

  // Polyphony register, saturated into its legal range on a write transfer.
  always_comb begin
    poly_wr = pwdata[POLY_W-1:0];
    if (poly_wr < POLY_MIN) poly_wr = POLY_MIN;
    else if (poly_wr > POLY_MAX) poly_wr = POLY_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) poly_r <= POLY_MAX;
    else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) poly_r <= poly_wr;
  end

  assign pready = 1'b1;
  assign prdata = 32'(poly_r);

  sva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sva_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_channel    (in_channel),
    .in_note       (in_note),
    .in_velocity   (in_velocity),
    .in_pedal_down (in_pedal_down),
    .in_voice_slot (in_voice_slot),
    .in_level      (in_level),
    .polyphony     (poly_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (res),
    .out_last      (out_last)
  );

  assign out_command = res.command;
  assign out_target_voice = res.voice;
  assign out_channel = res.channel;
  assign out_note = res.note;
  assign out_velocity = res.velocity;
  assign out_retrigger = res.retrigger;

endmodule

### tb/testbench.sv
// Self-checking testbench for the synth voice allocator with a built-in voice table predictor.
`timescale 1ns / 100ps

module testbench;
  import sva_pkg::*;

  // One key or control event as driven on the input channel.
  typedef struct {
    logic [2:0]  req;
    logic [3:0]  ch;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic        pedal;
    logic [3:0]  slot;
    logic [15:0] level;
  } event_t;

  // One voice command as seen on the result channel.
  typedef struct {
    logic [2:0] command;
    logic [3:0] voice;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
    logic       retrig;
    logic       last;
  } vcmd_t;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int NV = VOICE_COUNT;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [3:0]  in_channel;
  logic [6:0]  in_note;
  logic [6:0]  in_velocity;
  logic        in_pedal_down;
  logic [3:0]  in_voice_slot;
  logic [15:0] in_level;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_command;
  logic [3:0]  out_target_voice;
  logic [3:0]  out_channel;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic        out_retrigger;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  synth_voice_allocator dut (.*);

  // Clock.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shadow voice table.
  logic        v_active [NV];
  logic        v_rel [NV];
  logic [3:0]  v_ch [NV];
  logic [6:0]  v_note [NV];
  logic [31:0] v_age [NV];
  logic [15:0] v_level [NV];
  logic        v_held [NV];
  logic        pedal_is_down;
  logic [31:0] age_count;
  int          poly_limit;

  event_t pending_events[$];
  vcmd_t  event_cmds[$];
  vcmd_t  expected_cmds[$];
  int     error_count = 0;
  int     accepted_count = 0;

  // Collect one command of the current event.
  function automatic void add_cmd(logic [2:0] c, int v, logic [3:0] ch, logic [6:0] nt,
                                  logic [6:0] vel, logic rt);
    vcmd_t x;
    x.command = c;
    x.voice = v[3:0];
    x.ch = ch;
    x.note = nt;
    x.vel = vel;
    x.retrig = rt;
    x.last = 1'b0;
    event_cmds.push_back(x);
  endfunction

  function automatic logic is_sounding(int i);
    return v_active[i] && !v_rel[i];
  endfunction

  function automatic void launch_voice(int i, logic [2:0] c, event_t e);
    add_cmd(c, i, e.ch, e.note, e.vel, 1'b0);
    v_active[i] = 1'b1;
    v_rel[i] = 1'b0;
    v_ch[i] = e.ch;
    v_note[i] = e.note;
    v_level[i] = '0;
    v_held[i] = 1'b0;
    age_count = age_count + 1;
    v_age[i] = age_count;
  endfunction

  // Note on: fade releasing copies, retrigger, steal, then allocate.
  function automatic void strike_key(event_t e);
    int held_v;
    int count;
    int oldest;
    int target;
    logic rel;
    held_v = -1;
    count = 0;
    oldest = -1;
    target = -1;
    for (int i = 0; i < NV; i++) begin
      if (v_active[i] && v_ch[i] == e.ch && v_note[i] == e.note) begin
        if (v_rel[i]) add_cmd(CMD_FADE, i, '0, '0, '0, 1'b0);
        else held_v = i;
      end
    end
    if (held_v >= 0) begin
      v_held[held_v] = 1'b0;
      add_cmd(CMD_START, held_v, e.ch, e.note, e.vel, 1'b1);
      age_count = age_count + 1;
      v_age[held_v] = age_count;
      return;
    end
    for (int i = 0; i < NV; i++) begin
      if (is_sounding(i)) begin
        count++;
        if (oldest < 0 || v_age[i] < v_age[oldest]) oldest = i;
      end
    end
    if (count >= poly_limit && oldest >= 0) begin
      add_cmd(CMD_FADE, oldest, '0, '0, '0, 1'b0);
      v_rel[oldest] = 1'b1;
    end
    for (int i = 0; i < NV; i++) begin
      if (!v_active[i]) begin
        launch_voice(i, CMD_START, e);
        return;
      end
    end
    // Pool full: cut the quietest voice, releasing ones first.
    for (int i = 0; i < NV; i++) begin
      rel = v_rel[i];
      if (target < 0 || (rel && !v_rel[target]) ||
          (rel == v_rel[target] && v_level[i] < v_level[target]))
        target = i;
    end
    launch_voice(target, CMD_CUT, e);
  endfunction

  // Work out the commands of one accepted event and queue them.
  function automatic void predict_commands(event_t e);
    event_cmds.delete();
    case (e.req)
      REQ_NOTE_ON: strike_key(e);
      REQ_NOTE_OFF: begin
        for (int i = 0; i < NV; i++) begin
          if (is_sounding(i) && v_ch[i] == e.ch && v_note[i] == e.note) begin
            if (pedal_is_down) begin
              v_held[i] = 1'b1;
            end else begin
              add_cmd(CMD_RELEASE, i, '0, '0, e.vel, 1'b0);
              v_rel[i] = 1'b1;
            end
          end
        end
      end
      REQ_PEDAL: begin
        pedal_is_down = e.pedal;
        if (!e.pedal) begin
          for (int i = 0; i < NV; i++) begin
            if (v_held[i]) begin
              if (is_sounding(i)) begin
                add_cmd(CMD_RELEASE, i, '0, '0, '0, 1'b0);
                v_rel[i] = 1'b1;
              end
              v_held[i] = 1'b0;
            end
          end
        end
      end
      REQ_ALL_NOTES_OFF: begin
        for (int i = 0; i < NV; i++) begin
          if (is_sounding(i)) begin
            add_cmd(CMD_RELEASE, i, '0, '0, '0, 1'b0);
            v_rel[i] = 1'b1;
          end
          v_held[i] = 1'b0;
        end
        pedal_is_down = 1'b0;
      end
      REQ_ALL_SOUND_OFF: begin
        for (int i = 0; i < NV; i++) begin
          if (v_active[i]) add_cmd(CMD_SILENCE, i, '0, '0, '0, 1'b0);
          v_active[i] = 1'b0;
          v_rel[i] = 1'b0;
          v_level[i] = '0;
          v_held[i] = 1'b0;
        end
        pedal_is_down = 1'b0;
      end
      REQ_VOICE_FINISHED: begin
        v_active[e.slot] = 1'b0;
        v_rel[e.slot] = 1'b0;
        v_held[e.slot] = 1'b0;
        v_level[e.slot] = '0;
      end
      REQ_LEVEL_REPORT: v_level[e.slot] = e.level;
      default: ;
    endcase
    if (event_cmds.size() > 0) event_cmds[event_cmds.size()-1].last = 1'b1;
    foreach (event_cmds[k]) expected_cmds.push_back(event_cmds[k]);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  event_t cur_event;
  int     burst_left = 0;
  int     gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_commands(cur_event);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          cur_event = pending_events.pop_front();
          in_req_type <= cur_event.req;
          in_channel <= cur_event.ch;
          in_note <= cur_event.note;
          in_velocity <= cur_event.vel;
          in_pedal_down <= cur_event.pedal;
          in_voice_slot <= cur_event.slot;
          in_level <= cur_event.level;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the run is under way.
  int   hold_count = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
    end else if (!hold_done && accepted_count >= 150) begin
      hold_count <= 600;
      hold_done <= 1'b1;
    end
  end

  // Receiver stall pattern, whose character is drawn at random from four modes.
  int stall_mode = 0;
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= (hold_count > 0);
      1: out_stall <= (hold_count > 0) || ($urandom_range(0, 9) < 3);
      2: out_stall <= (hold_count > 0) || ($urandom_range(0, 9) < 7);
      default: out_stall <= (hold_count > 0) || (cycle_count % 3 == 0);
    endcase
  end

  // Monitor: compare each transfer with the oldest expected command.
  vcmd_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected command %0d to voice %0d", out_command, out_target_voice);
        error_count++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, out_command);
          error_count++;
        end
        if (out_target_voice !== want.voice) begin
          $error("target_voice: expected %0d, got %0d", want.voice, out_target_voice);
          error_count++;
        end
        if (out_channel !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_channel);
          error_count++;
        end
        if (out_note !== want.note) begin
          $error("out_note: expected %0d, got %0d", want.note, out_note);
          error_count++;
        end
        if (out_velocity !== want.vel) begin
          $error("out_velocity: expected %0d, got %0d", want.vel, out_velocity);
          error_count++;
        end
        if (out_retrigger !== want.retrig) begin
          $error("retrigger: expected %0d, got %0d", want.retrig, out_retrigger);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  function automatic event_t make_event(logic [2:0] req, logic [3:0] ch, logic [6:0] nt,
                                        logic [6:0] vel, logic pd, logic [3:0] slot,
                                        logic [15:0] lvl);
    event_t e;
    e.req = req;
    e.ch = ch;
    e.note = nt;
    e.vel = vel;
    e.pedal = pd;
    e.slot = slot;
    e.level = lvl;
    return e;
  endfunction

  // Random event, mostly on a small set of keys so that note offs hit.
  function automatic event_t random_event();
    event_t e;
    int r;
    r = $urandom_range(0, 99);
    e = make_event(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 4) != 0) begin
      e.ch = $urandom_range(0, 1) ? 4'd0 : 4'd9;
      e.note = 7'(60 + $urandom_range(0, 9));
    end
    if (r < 40) e.req = REQ_NOTE_ON;
    else if (r < 65) e.req = REQ_NOTE_OFF;
    else if (r < 72) e.req = REQ_PEDAL;
    else if (r < 74) e.req = REQ_ALL_NOTES_OFF;
    else if (r < 75) e.req = REQ_ALL_SOUND_OFF;
    else if (r < 83) e.req = REQ_VOICE_FINISHED;
    else if (r < 95) e.req = REQ_LEVEL_REPORT;
    else if (r < 97) e.req = REQ_UNUSED;
    return e;
  endfunction

  // Write the polyphony register through the APB port.
  task automatic write_polyphony(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (value[4:0] < POLY_MIN) poly_limit = POLY_MIN;
    else if (value[4:0] > POLY_MAX) poly_limit = POLY_MAX;
    else poly_limit = value[4:0];
  endtask

  // Wait until every event is taken and every command has arrived, then let
  // any event without commands finish inside the block.
  task automatic wait_drained();
    while (pending_events.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Stimulus and run control.
  initial begin
    logic [31:0] settings [5];
    settings = '{32'd16, 32'd0, 32'd31, 32'd3, 32'd1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_channel = '0;
    in_note = '0;
    in_velocity = '0;
    in_pedal_down = 1'b0;
    in_voice_slot = '0;
    in_level = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NV; i++) begin
      v_active[i] = 1'b0;
      v_rel[i] = 1'b0;
      v_ch[i] = '0;
      v_note[i] = '0;
      v_age[i] = '0;
      v_level[i] = '0;
      v_held[i] = 1'b0;
    end
    pedal_is_down = 1'b0;
    age_count = '0;
    poly_limit = 16;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events: key extremes, pedal hold, retrigger, fade, all offs.
    write_polyphony(settings[0]);
    pending_events.push_back(make_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd127, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_ON, 4'd0, 7'd0, 7'd0, 1'b1, 4'd15, '1));
    pending_events.push_back(make_event(REQ_LEVEL_REPORT, 4'd0, 7'd0, 7'd0, 1'b0, 4'd0, '1));
    pending_events.push_back(make_event(REQ_LEVEL_REPORT, 4'd0, 7'd0, 7'd0, 1'b0, 4'd1, '0));
    pending_events.push_back(make_event(REQ_PEDAL, 4'd0, 7'd0, 7'd0, 1'b1, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_OFF, 4'd15, 7'd127, 7'd99, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd55, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_OFF, 4'd15, 7'd127, 7'd12, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_PEDAL, 4'd0, 7'd0, 7'd0, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_ON, 4'd15, 7'd127, 7'd64, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_OFF, 4'd0, 7'd0, 7'd127, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_VOICE_FINISHED, 4'd0, 7'd0, 7'd0, 1'b0, 4'd1, '0));
    pending_events.push_back(make_event(REQ_UNUSED, 4'd3, 7'd3, 7'd3, 1'b1, 4'd3, 16'h5a5a));
    pending_events.push_back(make_event(REQ_NOTE_ON, 4'd2, 7'd40, 7'd90, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_PEDAL, 4'd0, 7'd0, 7'd0, 1'b1, 4'd0, '0));
    pending_events.push_back(make_event(REQ_NOTE_OFF, 4'd2, 7'd40, 7'd1, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_ALL_NOTES_OFF, 4'd0, 7'd0, 7'd0, 1'b0, 4'd0, '0));
    pending_events.push_back(make_event(REQ_ALL_SOUND_OFF, 4'd0, 7'd0, 7'd0, 1'b0, 4'd0, '0));
    // Fill the pool past its size so the quietest voice is cut.
    for (int i = 0; i < 18; i++)
      pending_events.push_back(make_event(REQ_NOTE_ON, 4'd5, 7'(i + 20), 7'(i), 1'b0, 4'd0,
                                          '0));
    pending_events.push_back(make_event(REQ_ALL_SOUND_OFF, 4'd0, 7'd0, 7'd0, 1'b0, 4'd0, '0));

    // Random phases, one per polyphony setting.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_drained();
        write_polyphony(settings[p]);
      end
      for (int n = 0; n < 80; n++) pending_events.push_back(random_event());
    end

    wait_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### synth_voice_allocator.f
rtl/sva_pkg.sv
rtl/sva_ctrl.sv
rtl/sva_datapath.sv
rtl/synth_voice_allocator.sv
tb/testbench.sv
